@@ design/ntc_b_equation_temperature_unit_macros.svh @@
// Assertion helpers used by the temperature unit design file.
`ifndef NTC_B_EQUATION_TEMPERATURE_UNIT_MACROS_SVH
`define NTC_B_EQUATION_TEMPERATURE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define NTC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NTC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define NTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/ntc_pkg.sv @@
package ntc_pkg;
   localparam int X_W = 20;
   localparam int K_W = 5;
   localparam int LOG_FRAC = 24;
   localparam int LOG_W = K_W + LOG_FRAC;
   localparam int MANT_SHIFT = 30;
   localparam int MANT_W = MANT_SHIFT + 1;
   localparam int MAG_W = 30;
   localparam logic [MAG_W-1:0] LN2_Q30 = 30'd744261118;
   localparam int TERM_N = MAG_W + 16;
   localparam int INV_Q = 46;
   localparam int SCALE_W = 47;
   localparam logic [SCALE_W-1:0] INV_SCALE = 47'd109951162777600;
   localparam int INV_W = 48;
   localparam int T_Q = 17;
   localparam logic [16:0] KELVIN_CENTI = 17'd27315;
   localparam logic [T_Q-1:0] Q_MAX = 17'd60082;
   localparam logic [15:0] T_MAX = 16'h7fff;

   typedef enum logic [2:0] {
      REG_ENABLED = 3'd0,
      REG_SERIES  = 3'd1,
      REG_NOMINAL = 3'd2,
      REG_T0      = 3'd3,
      REG_BETA    = 3'd4
   } reg_index_type;
endpackage

@@ design/ntc_b_equation_temperature_unit.sv @@
// Converts one divider converter code per beat into a thermistor temperature by the beta
// equation, in hundredths of a degree Celsius, with a valid flag on rsp_tuser. The datapath
// is a 95-stage pipeline that takes a new code every cycle while the output is not stalled:
// four 25-stage log2 units, a 47-stage long divider for ln/beta (beside one for the nominal
// inverse temperature), and an 18-stage divider for the final reciprocal. When rsp_tready
// is low with a result waiting, the whole pipeline holds. Registers may only be written
// while no beat is in flight.
`include "ntc_b_equation_temperature_unit_macros.svh"
module ntc_b_equation_temperature_unit #(
   parameter int ADC_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // adc_code
   input  logic [((ADC_BITS+7)/8)*8-1:0]          req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // temp_centi
   output logic [15:0]                            rsp_tdata,
   // valid_res
   output logic                                   rsp_tuser,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [4:0]                             csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);
   import ntc_pkg::*;

   localparam logic [ADC_BITS-1:0] FS = '1;
   localparam int LOG_LAT = LOG_FRAC + 1;
   localparam int DIV1_LAT = INV_Q + 1;
   localparam int DIV2_LAT = T_Q + 1;
   localparam int PIPE = LOG_LAT + 2 + DIV1_LAT + 2 + DIV2_LAT;

   logic enabled_ff;
   logic [19:0] series_ff, nominal_ff;
   logic [14:0] t0_ff;
   logic [13:0] beta_ff;
   logic csr_wr;
   reg_index_type csr_idx;

   logic en;
   logic [PIPE-1:0] vld_ff;
   logic [ADC_BITS-1:0] code;
   logic ok_in, ok_d;
   logic [LOG_W-1:0] ls, lc, lf, ln;
   logic [LOG_W:0] sum_p, sum_n;
   logic signed [LOG_W+1:0] l2_in;
   logic [MAG_W-1:0] mag_ff;
   logic neg_ff, neg_d;
   logic [2*MAG_W-1:0] prod_ff;
   logic [16:0] t0k_w;
   logic [INV_Q-1:0] term_q, inv0_q;
   logic [INV_W-1:0] inv_ff;
   logic pos;
   logic [INV_W-2:0] d_w;
   logic [INV_W-1:0] num_in, num_ff;
   logic [INV_W-2:0] den_ff;
   logic sat_in, sat_ff, sat_d;
   logic [T_Q-1:0] q_w;
   logic [T_Q:0] t_w;
   logic [15:0] temp_in;
   logic rsp_vld_ff;
   logic [15:0] rsp_data_ff;
   logic rsp_user_ff;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         series_ff <= 20'd10000;
         nominal_ff <= 20'd10000;
         t0_ff <= 15'd2500;
         beta_ff <= 14'd3950;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ENABLED: enabled_ff <= csr_pwdata[0];
            REG_SERIES:  series_ff <= csr_pwdata[19:0];
            REG_NOMINAL: nominal_ff <= csr_pwdata[19:0];
            REG_T0:      t0_ff <= csr_pwdata[14:0];
            REG_BETA:    beta_ff <= csr_pwdata[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ENABLED: csr_prdata = 32'(enabled_ff);
         REG_SERIES:  csr_prdata = 32'(series_ff);
         REG_NOMINAL: csr_prdata = 32'(nominal_ff);
         REG_T0:      csr_prdata = 32'(t0_ff);
         REG_BETA:    csr_prdata = 32'(beta_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign en = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE-2:0], req_tvalid};
         rsp_vld_ff <= vld_ff[PIPE-1];
      end
   end

   assign code = req_tdata[ADC_BITS-1:0];
   assign ok_in = enabled_ff && (code != '0) && (code != FS) && (series_ff != '0)
                  && (nominal_ff != '0) && (beta_ff != '0);

   ntc_delay #(.W(1), .DEPTH(PIPE)) u_ok (
      .clock(clock), .en(en), .din(ok_in), .dout(ok_d));

   ntc_log2 u_log_s (.clock(clock), .en(en), .x(series_ff), .log2_q(ls));
   ntc_log2 u_log_c (.clock(clock), .en(en), .x(X_W'(code)), .log2_q(lc));
   ntc_log2 u_log_f (.clock(clock), .en(en), .x(X_W'(FS - code)), .log2_q(lf));
   ntc_log2 u_log_n (.clock(clock), .en(en), .x(nominal_ff), .log2_q(ln));

   assign sum_p = {1'b0, ls} + {1'b0, lc};
   assign sum_n = {1'b0, lf} + {1'b0, ln};
   assign l2_in = $signed({1'b0, sum_p}) - $signed({1'b0, sum_n});

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= l2_in[LOG_W+1];
         mag_ff <= l2_in[LOG_W+1] ? MAG_W'(-l2_in) : MAG_W'(l2_in);
         prod_ff <= mag_ff * LN2_Q30;
      end
   end

   ntc_delay #(.W(1), .DEPTH(1 + DIV1_LAT)) u_neg (
      .clock(clock), .en(en), .din(neg_ff), .dout(neg_d));

   assign t0k_w = {{2{t0_ff[14]}}, t0_ff} + KELVIN_CENTI;

   ntc_div #(.N(TERM_N), .D(14), .Q(INV_Q)) u_div_term (
      .clock(clock), .en(en),
      .num({prod_ff[2*MAG_W-1:MANT_SHIFT], 16'b0}),
      .den(beta_ff), .quo(term_q));

   ntc_div #(.N(SCALE_W), .D(16), .Q(INV_Q)) u_div_inv0 (
      .clock(clock), .en(en), .num(INV_SCALE), .den(t0k_w[15:0]), .quo(inv0_q));

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff <= neg_d ? ({2'b0, inv0_q} - {2'b0, term_q})
                         : ({2'b0, inv0_q} + {2'b0, term_q});
      end
   end

   assign pos = !inv_ff[INV_W-1] && (inv_ff != '0);
   assign d_w = inv_ff[INV_W-2:0];
   assign num_in = {1'b0, INV_SCALE} + INV_W'(d_w >> 1);
   assign sat_in = !pos || ({(T_Q+1)'(0), num_in} >= (INV_W+T_Q+1)'({d_w, {T_Q{1'b0}}}));

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= d_w;
         sat_ff <= sat_in;
      end
   end

   ntc_delay #(.W(1), .DEPTH(DIV2_LAT)) u_sat (
      .clock(clock), .en(en), .din(sat_ff), .dout(sat_d));

   ntc_div #(.N(INV_W), .D(INV_W-1), .Q(T_Q)) u_div_t (
      .clock(clock), .en(en), .num(num_ff), .den(den_ff), .quo(q_w));

   assign t_w = {1'b0, q_w} - (T_Q+1)'(KELVIN_CENTI);

   always_comb begin
      if (!ok_d) begin
         temp_in = '0;
      end else if (sat_d || (q_w > Q_MAX)) begin
         temp_in = T_MAX;
      end else begin
         temp_in = t_w[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= temp_in;
         rsp_user_ff <= ok_d;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   `NTC_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "invalid beat carries a nonzero temperature")
   `NTC_ASSERT_NEXT(a_sat_max, clock, reset, en && vld_ff[PIPE-1] && ok_d && sat_d, rsp_tvalid && rsp_tuser && (rsp_tdata == T_MAX), "saturated beat not at the upper limit")
   `NTC_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid, "result valid straight after reset")
endmodule

@@ design/ntc_delay.sv @@
module ntc_delay #(
   parameter int W = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];
endmodule

@@ design/ntc_log2.sv @@
module ntc_log2 (
   input  logic                       clock,
   input  logic                       en,
   input  logic [ntc_pkg::X_W-1:0]    x,
   output logic [ntc_pkg::LOG_W-1:0]  log2_q
);
   import ntc_pkg::*;

   logic [K_W-1:0] k_in;
   logic [X_W+MANT_SHIFT-1:0] wide_in;
   logic [MANT_W-1:0] m_ff [LOG_FRAC+1];
   logic [LOG_W-1:0] r_ff [LOG_FRAC+1];

   always_comb begin
      k_in = '0;
      for (int b = 0; b < X_W; b++) begin
         if (x[b]) begin
            k_in = K_W'(b);
         end
      end
      wide_in = {x, {MANT_SHIFT{1'b0}}} >> k_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= wide_in[MANT_W-1:0];
         r_ff[0] <= {k_in, {LOG_FRAC{1'b0}}};
      end
   end

   for (genvar s = 0; s < LOG_FRAC; s++) begin : g_sq
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0] mm;
      assign sq = m_ff[s] * m_ff[s];
      assign mm = sq[2*MANT_W-1:MANT_SHIFT];
      always_ff @(posedge clock) begin
         if (en) begin
            if (mm[MANT_W]) begin
               m_ff[s+1] <= mm[MANT_W:1];
               r_ff[s+1] <= r_ff[s] | (LOG_W'(1) << (LOG_FRAC - 1 - s));
            end else begin
               m_ff[s+1] <= mm[MANT_W-1:0];
               r_ff[s+1] <= r_ff[s];
            end
         end
      end
   end

   assign log2_q = r_ff[LOG_FRAC];
endmodule

@@ design/ntc_div.sv @@
module ntc_div #(
   parameter int N = 8,
   parameter int D = 8,
   parameter int Q = 8
) (
   input  logic         clock,
   input  logic         en,
   input  logic [N-1:0] num,
   input  logic [D-1:0] den,
   output logic [Q-1:0] quo
);
   logic [N-1:0] rem_ff [Q];
   logic [D-1:0] den_ff [Q];
   logic [Q-1:0] quo_ff [Q+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < Q; s++) begin : g_bit
      logic [N+D-1:0] sh;
      logic ge;
      assign sh = (N+D)'(den_ff[s]) << (Q - 1 - s);
      assign ge = (N+D)'(rem_ff[s]) >= sh;
      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[s+1] <= quo_ff[s] | (ge ? (Q'(1) << (Q - 1 - s)) : Q'(0));
         end
      end
      if (s < Q - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s+1] <= ge ? rem_ff[s] - sh[N-1:0] : rem_ff[s];
               den_ff[s+1] <= den_ff[s];
            end
         end
      end
   end

   assign quo = quo_ff[Q];
endmodule
